[src/hem_pkg.sv]
// Shared types and constants for the haptic envelope mixer.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package hem_pkg;

  localparam int SHOT_SLOTS = 12;
  localparam int CHANNELS   = 3;
  localparam int LEVEL_MAX  = 65535;

  localparam int SLOT_AW = (SHOT_SLOTS > 1) ? $clog2(SHOT_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(SHOT_SLOTS + 1);
  localparam int SUM_W   = 16 + $clog2(SHOT_SLOTS + CHANNELS + 1);
  localparam int DVD_W   = 27;

  localparam logic [7:0] HOLD_TICS_RST = 8'd6;
  localparam logic [9:0] CMD_HOLD_RST  = 10'd200;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;
  localparam logic [1:0] OP_STOP    = 2'd3;

  localparam logic CFG_HOLD_TICS = 1'b0;
  localparam logic CFG_CMD_HOLD  = 1'b1;

  typedef struct packed {
    logic signed [11:0] delay;
    logic [15:0]        start_low;
    logic [15:0]        start_high;
    logic [15:0]        end_low;
    logic [15:0]        end_high;
    logic [10:0]        elapsed;
    logic [9:0]         length;
  } slot_t;

endpackage
`default_nettype wire

[src/haptic_envelope_mixer.sv]
// Top level of the haptic envelope mixer: sequencer, channel registers, mixing.
// Depends on hem_pkg, hem_slot_ram and hem_div.
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   opcode .. channel
//  out       source     out_valid_o / out_stall_i motor_low, motor_high, hold_ms
//  cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// A tick walks the slot table one entry at a time; an active ramping slot
// waits on the one-bit-a-cycle divider. Reset clears the active bits and
// channel holds and sets the idle flag at once; the slot memory needs no
// clearing since an inactive entry is never read. A result waits in the
// output register; only the final hand-off of a new beat waits on out_stall_i.
`default_nettype none
module haptic_envelope_mixer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  opcode_i,
  input  wire  [7:0]  tics_i,
  input  wire  [9:0]  delay_i,
  input  wire  [15:0] start_low_i,
  input  wire  [15:0] start_high_i,
  input  wire  [15:0] end_low_i,
  input  wire  [15:0] end_high_i,
  input  wire  [9:0]  duration_i,
  input  wire  [1:0]  channel_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] motor_low_o,
  output logic [15:0] motor_high_o,
  output logic [9:0]  hold_ms_o,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [9:0]  cfg_data_i
);

  localparam int AW = hem_pkg::SLOT_AW;
  localparam int CW = hem_pkg::SLOT_CW;
  localparam int SW = hem_pkg::SUM_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EXE  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DST  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]  state_q;
  logic [7:0]  hold_tics_q;
  logic [9:0]  cmd_hold_q;
  logic [hem_pkg::SHOT_SLOTS-1:0] active_q;
  logic [15:0]       chan_lo_q   [hem_pkg::CHANNELS];
  logic [15:0]       chan_hi_q   [hem_pkg::CHANNELS];
  logic signed [8:0] chan_hold_q [hem_pkg::CHANNELS];
  logic        idle_q;
  logic [CW-1:0] idx_q;
  logic [7:0]  tics_q;
  logic [SW-1:0] sum_lo_q, sum_hi_q;
  logic        is_stop_q;

  // Working registers for one slot.
  hem_pkg::slot_t cur_q;
  logic [9:0]  pos_q;
  logic signed [16:0] dlo_q, dhi_q;
  logic signed [27:0] plo_q, phi_q;

  logic        out_valid_q;
  logic [15:0] out_lo_q, out_hi_q;
  logic [9:0]  out_ms_q;

  logic        in_acc, out_free;
  logic [AW-1:0] free_idx;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  hem_pkg::slot_t ram_wdata, ram_rdata, new_slot;
  logic [10:0] el_new;
  logic        div_done, div_done_lo, div_done_hi;
  logic [15:0] q_lo, q_hi;
  logic [hem_pkg::DVD_W-1:0] mag_lo, mag_hi;
  logic [16:0] pt_lo, pt_hi;
  logic [SW-1:0] mix_lo, mix_hi;
  logic [15:0] sat_lo, sat_hi;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // First free slot, or slot 0 when the table is full.
  always_comb begin
    free_idx = '0;
    for (int i = hem_pkg::SHOT_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  always_comb begin
    new_slot.delay      = {2'b00, delay_i};
    new_slot.start_low  = start_low_i;
    new_slot.start_high = start_high_i;
    new_slot.end_low    = end_low_i;
    new_slot.end_high   = end_high_i;
    new_slot.elapsed    = '0;
    new_slot.length     = (duration_i == '0) ? 10'd1 : duration_i;
  end

  // The slot just read either counts down its delay or advances its ramp.
  assign el_new = ram_rdata.elapsed + 11'(tics_q);

  always_comb begin
    ram_wdata = ram_rdata;
    if (ram_rdata.delay > 0) begin
      ram_wdata.delay = ram_rdata.delay - $signed({4'b0000, tics_q});
    end else begin
      ram_wdata.elapsed = el_new;
    end
  end

  assign ram_we    = (in_acc && opcode_i == hem_pkg::OP_ADD) || (state_q == ST_EXE);
  assign ram_waddr = (state_q == ST_EXE) ? idx_q[AW-1:0] : free_idx;
  assign ram_re    = (state_q == ST_RD) && (idx_q != CW'(hem_pkg::SHOT_SLOTS))
                     && active_q[idx_q[AW-1:0]];

  hem_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((state_q == ST_EXE) ? ram_wdata : new_slot),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign mag_lo = plo_q[27] ? 27'(-plo_q) : plo_q[26:0];
  assign mag_hi = phi_q[27] ? 27'(-phi_q) : phi_q[26:0];

  hem_div u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DST),
    .dividend_i (mag_lo),
    .divisor_i  (cur_q.length),
    .done_o     (div_done_lo),
    .quotient_o (q_lo)
  );

  hem_div u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DST),
    .dividend_i (mag_hi),
    .divisor_i  (cur_q.length),
    .done_o     (div_done_hi),
    .quotient_o (q_hi)
  );

  // Both dividers run in lock step; the walk moves on once both have finished.
  assign div_done = div_done_lo && div_done_hi;

  // Division truncates toward zero; the product's sign picks add or subtract.
  assign pt_lo = plo_q[27] ? ({1'b0, cur_q.start_low} - {1'b0, q_lo})
                           : ({1'b0, cur_q.start_low} + {1'b0, q_lo});
  assign pt_hi = phi_q[27] ? ({1'b0, cur_q.start_high} - {1'b0, q_hi})
                           : ({1'b0, cur_q.start_high} + {1'b0, q_hi});

  // Live channels join the slot sums after the walk.
  always_comb begin
    mix_lo = sum_lo_q;
    mix_hi = sum_hi_q;
    for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
      if (chan_hold_q[c] > 0) begin
        mix_lo = mix_lo + SW'(chan_lo_q[c]);
        mix_hi = mix_hi + SW'(chan_hi_q[c]);
      end
    end
    sat_lo = (mix_lo > SW'(hem_pkg::LEVEL_MAX)) ? 16'hFFFF : mix_lo[15:0];
    sat_hi = (mix_hi > SW'(hem_pkg::LEVEL_MAX)) ? 16'hFFFF : mix_hi[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_tics_q <= hem_pkg::HOLD_TICS_RST;
      cmd_hold_q  <= hem_pkg::CMD_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hem_pkg::CFG_HOLD_TICS: hold_tics_q <= cfg_data_i[7:0];
        hem_pkg::CFG_CMD_HOLD:  cmd_hold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      idle_q      <= 1'b1;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      is_stop_q   <= 1'b0;
      for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
        chan_hold_q[c] <= '0;
      end
    end else begin
      // The output state sets the valid flag itself when it hands a beat over.
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (opcode_i)
              hem_pkg::OP_ADD: begin
                active_q[free_idx] <= 1'b1;
              end
              hem_pkg::OP_REFRESH: begin
                for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
                  if (32'(channel_i) == c) begin
                    chan_hold_q[c] <= $signed({1'b0, hold_tics_q});
                  end
                end
              end
              hem_pkg::OP_STOP: begin
                active_q  <= '0;
                for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
                  chan_hold_q[c] <= '0;
                end
                is_stop_q <= 1'b1;
                state_q   <= ST_OUT;
              end
              default: begin
                is_stop_q <= 1'b0;
                idx_q     <= '0;
                state_q   <= ST_RD;
              end
            endcase
          end
        end
        ST_RD: begin
          if (idx_q == CW'(hem_pkg::SHOT_SLOTS)) begin
            for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
              if (chan_hold_q[c] > 0) begin
                chan_hold_q[c] <= chan_hold_q[c] - $signed({1'b0, tics_q});
              end
            end
            state_q <= ST_OUT;
          end else if (ram_re) begin
            state_q <= ST_EXE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_EXE: begin
          if (ram_rdata.delay > 0) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_RD;
          end else begin
            if (el_new >= {1'b0, ram_rdata.length}) begin
              active_q[idx_q[AW-1:0]] <= 1'b0;
            end
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_DST;
        ST_DST: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= ST_RD;
        end
        ST_OUT: begin
          if (out_free) begin
            if (is_stop_q) begin
              out_valid_q <= !idle_q;
              idle_q      <= 1'b1;
            end else if (sum_lo_q == '0 && sum_hi_q == '0) begin
              out_valid_q <= !idle_q;
              idle_q      <= 1'b1;
            end else begin
              out_valid_q <= 1'b1;
              idle_q      <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == hem_pkg::OP_REFRESH) begin
      for (int c = 0; c < hem_pkg::CHANNELS; c++) begin
        if (32'(channel_i) == c) begin
          chan_lo_q[c] <= start_low_i;
          chan_hi_q[c] <= start_high_i;
        end
      end
    end
    if (in_acc && opcode_i == hem_pkg::OP_TICK) begin
      tics_q   <= (tics_i == '0) ? 8'd1 : tics_i;
      sum_lo_q <= '0;
      sum_hi_q <= '0;
    end
    if (state_q == ST_EXE) begin
      cur_q <= ram_rdata;
      pos_q <= (el_new > {1'b0, ram_rdata.length}) ? ram_rdata.length : el_new[9:0];
      dlo_q <= $signed({1'b0, ram_rdata.end_low}) - $signed({1'b0, ram_rdata.start_low});
      dhi_q <= $signed({1'b0, ram_rdata.end_high}) - $signed({1'b0, ram_rdata.start_high});
    end
    if (state_q == ST_MUL) begin
      plo_q <= 28'(dlo_q * $signed({1'b0, pos_q}));
      phi_q <= 28'(dhi_q * $signed({1'b0, pos_q}));
    end
    if (state_q == ST_ACC) begin
      sum_lo_q <= sum_lo_q + SW'(pt_lo);
      sum_hi_q <= sum_hi_q + SW'(pt_hi);
    end
    if (state_q == ST_RD && idx_q == CW'(hem_pkg::SHOT_SLOTS)) begin
      sum_lo_q <= SW'(sat_lo);
      sum_hi_q <= SW'(sat_hi);
    end
    if (state_q == ST_OUT && out_free) begin
      if (is_stop_q || (sum_lo_q == '0 && sum_hi_q == '0)) begin
        out_lo_q <= '0;
        out_hi_q <= '0;
        out_ms_q <= '0;
      end else begin
        out_lo_q <= sum_lo_q[15:0];
        out_hi_q <= sum_hi_q[15:0];
        out_ms_q <= cmd_hold_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign motor_low_o  = out_lo_q;
  assign motor_high_o = out_hi_q;
  assign hold_ms_o    = out_ms_q;

endmodule
`default_nettype wire

[src/hem_slot_ram.sv]
// Slot table memory: one write port, one read port, registered read data.
// Depends on hem_pkg for the slot word and depth.
`default_nettype none
module hem_slot_ram (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire [hem_pkg::SLOT_AW-1:0]   waddr_i,
  input  wire hem_pkg::slot_t          wdata_i,
  input  wire                          re_i,
  input  wire [hem_pkg::SLOT_AW-1:0]   raddr_i,
  output hem_pkg::slot_t               rdata_o
);

  hem_pkg::slot_t mem [hem_pkg::SHOT_SLOTS];
  hem_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/hem_div.sv]
// Restoring serial divider, one quotient bit per cycle, for ramp points.
// Depends on hem_pkg for the dividend width.
`default_nettype none
module hem_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [hem_pkg::DVD_W-1:0]   dividend_i,
  input  wire [9:0]                  divisor_i,
  output logic                       done_o,
  output logic [15:0]                quotient_o
);

  localparam int CNT_W = $clog2(hem_pkg::DVD_W + 1);

  logic [9:0]                rem_q;
  logic [hem_pkg::DVD_W-1:0] shf_q;
  logic [9:0]                dsr_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [10:0]               trial;
  logic                      fits;

  assign trial = {rem_q, shf_q[hem_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(hem_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      shf_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 10'(trial - {1'b0, dsr_q}) : trial[9:0];
      shf_q <= {shf_q[hem_pkg::DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shf_q[15:0];

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the haptic envelope mixer: random bursts of commands,
// a patterned output stall and a scoreboard that predicts every drive beat.
// Depends on hem_pkg and the RTL under src.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One command beat as it crosses the input channel.
  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  tics;
    logic [9:0]  delay;
    logic [15:0] start_low;
    logic [15:0] start_high;
    logic [15:0] end_low;
    logic [15:0] end_high;
    logic [9:0]  duration;
    logic [1:0]  channel;
  } cmd_t;

  // One drive command as it leaves the output channel.
  typedef struct {
    logic [15:0] motor_low;
    logic [15:0] motor_high;
    logic [9:0]  hold_ms;
  } drive_t;

  // The scoreboard keeps its own copy of the slot table and the channels and
  // works out, for every accepted command, the drive beat (if any) it causes.
  class rumble_scoreboard;
    int unsigned hold_tics;
    int unsigned cmd_hold_ms;
    bit          active[hem_pkg::SHOT_SLOTS];
    int          dly[hem_pkg::SHOT_SLOTS];
    int          s_lo[hem_pkg::SHOT_SLOTS];
    int          s_hi[hem_pkg::SHOT_SLOTS];
    int          e_lo[hem_pkg::SHOT_SLOTS];
    int          e_hi[hem_pkg::SHOT_SLOTS];
    int          elapsed[hem_pkg::SHOT_SLOTS];
    int          len[hem_pkg::SHOT_SLOTS];
    int          ch_lo[hem_pkg::CHANNELS];
    int          ch_hi[hem_pkg::CHANNELS];
    int          ch_hold[hem_pkg::CHANNELS];
    bit          idle;
    drive_t      pending[$];
    int          failures;

    function new();
      hold_tics   = hem_pkg::HOLD_TICS_RST;
      cmd_hold_ms = hem_pkg::CMD_HOLD_RST;
      clear_mix();
      idle     = 1'b1;
      failures = 0;
    endfunction

    function void clear_mix();
      for (int i = 0; i < hem_pkg::SHOT_SLOTS; i++) begin
        active[i] = 0; dly[i] = 0; s_lo[i] = 0; s_hi[i] = 0;
        e_lo[i] = 0; e_hi[i] = 0; elapsed[i] = 0; len[i] = 0;
      end
      for (int i = 0; i < hem_pkg::CHANNELS; i++) begin
        ch_lo[i] = 0; ch_hi[i] = 0; ch_hold[i] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [9:0] data);
      if (idx == hem_pkg::CFG_HOLD_TICS) hold_tics = data[7:0];
      else cmd_hold_ms = data;
    endfunction

    // Linear interpolation; signed division truncates toward zero.
    function int ramp_at(int from, int to, int pos, int span);
      longint d;
      d = longint'(to - from) * longint'(pos);
      return from + int'(d / longint'(span));
    endfunction

    function void push_drive(int lo, int hi, int ms);
      drive_t d;
      d.motor_low  = lo[15:0];
      d.motor_high = hi[15:0];
      d.hold_ms    = ms[9:0];
      pending.push_back(d);
    endfunction

    function void note_beat(cmd_t c);
      int t, tgt, pos, sum_lo, sum_hi, span;
      case (c.opcode)
        hem_pkg::OP_ADD: begin
          span = (c.duration == 0) ? 1 : int'(c.duration);
          tgt = 0;
          for (int i = hem_pkg::SHOT_SLOTS - 1; i >= 0; i--) if (!active[i]) tgt = i;
          active[tgt] = 1; dly[tgt] = c.delay;
          s_lo[tgt] = c.start_low; s_hi[tgt] = c.start_high;
          e_lo[tgt] = c.end_low; e_hi[tgt] = c.end_high;
          elapsed[tgt] = 0; len[tgt] = span;
        end
        hem_pkg::OP_REFRESH: begin
          if (c.channel < hem_pkg::CHANNELS) begin
            ch_lo[c.channel] = c.start_low;
            ch_hi[c.channel] = c.start_high;
            ch_hold[c.channel] = hold_tics;
          end
        end
        hem_pkg::OP_STOP: begin
          clear_mix();
          if (!idle) push_drive(0, 0, 0);
          idle = 1'b1;
        end
        default: begin
          t = (c.tics == 0) ? 1 : int'(c.tics);
          sum_lo = 0; sum_hi = 0;
          for (int i = 0; i < hem_pkg::SHOT_SLOTS; i++) begin
            if (!active[i]) continue;
            if (dly[i] > 0) begin
              dly[i] -= t;
              continue;
            end
            elapsed[i] += t;
            pos = (elapsed[i] > len[i]) ? len[i] : elapsed[i];
            sum_lo += ramp_at(s_lo[i], e_lo[i], pos, len[i]);
            sum_hi += ramp_at(s_hi[i], e_hi[i], pos, len[i]);
            if (elapsed[i] >= len[i]) active[i] = 0;
          end
          for (int i = 0; i < hem_pkg::CHANNELS; i++) begin
            if (ch_hold[i] <= 0) begin
              ch_lo[i] = 0; ch_hi[i] = 0;
              continue;
            end
            ch_hold[i] -= t;
            sum_lo += ch_lo[i];
            sum_hi += ch_hi[i];
          end
          if (sum_lo > hem_pkg::LEVEL_MAX) sum_lo = hem_pkg::LEVEL_MAX;
          if (sum_hi > hem_pkg::LEVEL_MAX) sum_hi = hem_pkg::LEVEL_MAX;
          if (sum_lo == 0 && sum_hi == 0) begin
            if (!idle) push_drive(0, 0, 0);
            idle = 1'b1;
          end else begin
            idle = 1'b0;
            push_drive(sum_lo, sum_hi, cmd_hold_ms);
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures++;
    endtask

    task check_beat(drive_t got);
      drive_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected drive %0d/%0d/%0d",
                         got.motor_low, got.motor_high, got.hold_ms));
      end else begin
        want = pending.pop_front();
        if (got.motor_low !== want.motor_low)
          report($sformatf("motor_low %0d, wanted %0d", got.motor_low, want.motor_low));
        if (got.motor_high !== want.motor_high)
          report($sformatf("motor_high %0d, wanted %0d", got.motor_high, want.motor_high));
        if (got.hold_ms !== want.hold_ms)
          report($sformatf("hold_ms %0d, wanted %0d", got.hold_ms, want.hold_ms));
      end
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  tics_i;
  logic [9:0]  delay_i;
  logic [15:0] start_low_i, start_high_i, end_low_i, end_high_i;
  logic [9:0]  duration_i;
  logic [1:0]  channel_i;
  logic        out_valid_o, out_stall_i;
  logic [15:0] motor_low_o, motor_high_o;
  logic [9:0]  hold_ms_o;
  logic        cfg_we_i, cfg_index_i;
  logic [9:0]  cfg_data_i;

  rumble_scoreboard sb = new();
  int  burst_left = 0;
  // Set by the main sequence to ask the receiver for one long hold-off.
  bit  hold_off_req = 0;

  haptic_envelope_mixer u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // All inputs start at known values; the main sequence releases reset.
  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i <= hem_pkg::OP_TICK; tics_i <= '0; delay_i <= '0;
    start_low_i <= '0; start_high_i <= '0; end_low_i <= '0; end_high_i <= '0;
    duration_i <= '0; channel_i <= '0;
    cfg_we_i <= 1'b0; cfg_index_i <= hem_pkg::CFG_HOLD_TICS; cfg_data_i <= '0;
    out_stall_i <= 1'b0;
  end

  // Receiver: stretches of free flow alternate with stretches of random
  // stalling; one long hold-off on request lets the block back up its input.
  initial begin
    int mode_left, hold_left;
    bit choppy;
    mode_left = 0; hold_left = 0; choppy = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && hold_left == 0) begin
        hold_off_req = 0;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        choppy = $urandom_range(0, 1);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= choppy ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
    end
  end

  // Every beat leaving the block is checked against the oldest prediction.
  always @(posedge clk_i) begin
    drive_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.motor_low  = motor_low_o;
      got.motor_high = motor_high_o;
      got.hold_ms    = hold_ms_o;
      sb.check_beat(got);
    end
  end

  // Offers one command and returns at the edge where it is taken. Valid is
  // dropped only for a real gap between bursts, never lowered and raised at
  // the same edge.
  task send_beat(cmd_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    opcode_i <= c.opcode; tics_i <= c.tics; delay_i <= c.delay;
    start_low_i <= c.start_low; start_high_i <= c.start_high;
    end_low_i <= c.end_low; end_high_i <= c.end_high;
    duration_i <= c.duration; channel_i <= c.channel;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(c);
  endtask

  function cmd_t make_cmd(logic [1:0] op, int tics, int dly, int slo, int shi,
                          int elo, int ehi, int dur, int ch);
    cmd_t c;
    c.opcode = op; c.tics = tics; c.delay = dly;
    c.start_low = slo; c.start_high = shi; c.end_low = elo; c.end_high = ehi;
    c.duration = dur; c.channel = ch;
    return c;
  endfunction

  // Mostly well-formed play: short ramps, small tick steps and refreshes,
  // with occasional extremes and a little fully random noise.
  function cmd_t random_cmd();
    cmd_t c;
    int roll;
    c = make_cmd($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 1023),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 1023), $urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      c.opcode = hem_pkg::OP_TICK;
      if ($urandom_range(0, 9) != 0) c.tics = $urandom_range(0, 4);
    end else if (roll < 72) begin
      c.opcode = hem_pkg::OP_ADD;
      if ($urandom_range(0, 9) != 0) c.delay = $urandom_range(0, 5);
      if ($urandom_range(0, 9) != 0) c.duration = $urandom_range(0, 10);
      if ($urandom_range(0, 2) == 0) begin
        c.start_low = $urandom_range(0, 4000); c.end_low = $urandom_range(0, 4000);
      end
    end else if (roll < 90) begin
      c.opcode = hem_pkg::OP_REFRESH;
    end else if (roll < 94) begin
      c.opcode = hem_pkg::OP_STOP;
    end
    return c;
  endfunction

  // Waits until every prediction has been met, then lets the block finish any
  // silent tick before the caller touches the registers.
  task drain();
    if (burst_left != 0 || in_valid_i) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task write_reg(logic idx, logic [9:0] data);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] ht[4];
    logic [9:0] ch[4];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: idle tick and stop, extremes, falling ramp, full table,
    // out-of-range channel, zero tick count, stop while busy.
    send_beat(make_cmd(hem_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_ADD, 0, 0, 65535, 65535, 65535, 65535, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_ADD, 0, 0, 65535, 1000, 0, 0, 1023, 0));
    send_beat(make_cmd(hem_pkg::OP_TICK, 255, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < hem_pkg::SHOT_SLOTS + 1; i++)
      send_beat(make_cmd(hem_pkg::OP_ADD, 0, (i == 3) ? 1023 : i, 1000 * i,
                         65535 - 500 * i, 65535, 7 * i, i + 2, 0));
    send_beat(make_cmd(hem_pkg::OP_REFRESH, 0, 0, 1234, 4321, 0, 0, 0, 3));
    send_beat(make_cmd(hem_pkg::OP_REFRESH, 0, 0, 65535, 0, 0, 0, 0, 2));
    send_beat(make_cmd(hem_pkg::OP_TICK, 1, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_cmd(hem_pkg::OP_TICK, 3, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Register settings: short hold, extremes, zero hold and a hold time
    // written above its usual range.
    ht = '{8'd1, 8'd255, 8'd0, 8'd6};
    ch = '{10'd0, 10'd1000, 10'd1023, 10'd200};
    for (int p = 0; p < 4; p++) begin
      write_reg(hem_pkg::CFG_HOLD_TICS, ht[p]);
      write_reg(hem_pkg::CFG_CMD_HOLD, ch[p]);
      for (int n = 0; n < 138; n++) begin
        if (p == 1 && n == 40) hold_off_req = 1;
        send_beat(random_cmd());
      end
      drain();
    end

    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
